/* sv/pto_pkg.sv */
// types and codes shared by the order book cells and the top level
package pto_pkg;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_CANCEL = 3'd1;
  localparam logic [2:0] KIND_MODIFY = 3'd2;
  localparam logic [2:0] KIND_POPBUY = 3'd3;
  localparam logic [2:0] KIND_POPSEL = 3'd4;
  localparam logic [2:0] KIND_EXPIRE = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam logic [47:0] NO_EXPIRY = 48'hFFFF_FFFF_FFFF;
  localparam logic [6:0]  CNT_MAX   = 7'd127;

  typedef struct packed {
    logic        buy;
    logic [31:0] price;
    logic [31:0] qty;
    logic [30:0] id;
    logic [47:0] expiry;
  } rec_t;

  typedef struct packed {
    logic        has;
    logic [31:0] price;
    logic [30:0] id;
    logic [31:0] qty;
  } best_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic        rm_en;
    logic        ins_en;
    logic        by_id;
    logic [30:0] key;
    logic [46:0] now;
    rec_t        rec;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_INS,
    S_EXP,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

/* sv/pto_cell.sv */
// one order cell: holds a resting order, shifts down on removal, passes best-price wave up
module pto_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  pto_pkg::cmd_t cmd,
  input  logic          prev_valid,
  input  logic          next_valid,
  input  pto_pkg::rec_t next_rec,
  input  logic          rm_in,
  output logic          rm_out,
  output logic          valid_o,
  output pto_pkg::rec_t rec_o,
  output logic          match_o,
  output logic          ins_o,
  input  pto_pkg::best_t buy_in,
  input  pto_pkg::best_t sell_in,
  output pto_pkg::best_t buy_out,
  output pto_pkg::best_t sell_out
);

  logic           valid_r, valid_nxt;
  pto_pkg::rec_t  rec_r, rec_nxt;
  pto_pkg::best_t buy_r, buy_nxt, sell_r, sell_nxt;
  logic           expired;
  logic           shift;

  assign expired = (rec_r.expiry != pto_pkg::NO_EXPIRY) &&
                   ($signed(rec_r.expiry) <= $signed({1'b0, cmd.now}));
  assign match_o = valid_r && (cmd.by_id ? (rec_r.id == cmd.key) : expired);
  assign rm_out  = rm_in | match_o;
  assign shift   = cmd.rm_en & rm_out;
  assign ins_o   = cmd.ins_en & ~valid_r & prev_valid;

  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    if (shift) begin
      valid_nxt = next_valid;
      rec_nxt   = next_rec;
    end else if (ins_o) begin
      valid_nxt = 1'b1;
      rec_nxt   = cmd.rec;
    end
    buy_nxt  = buy_in;
    sell_nxt = sell_in;
    // strictly better only, so the lower cell keeps a tie
    if (valid_r && rec_r.buy && (!buy_in.has || rec_r.price > buy_in.price)) begin
      buy_nxt = '{has: 1'b1, price: rec_r.price, id: rec_r.id, qty: rec_r.qty};
    end
    if (valid_r && !rec_r.buy && (!sell_in.has || rec_r.price < sell_in.price)) begin
      sell_nxt = '{has: 1'b1, price: rec_r.price, id: rec_r.id, qty: rec_r.qty};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      buy_r.has  <= 1'b0;
      sell_r.has <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      buy_r.has  <= buy_nxt.has;
      sell_r.has <= sell_nxt.has;
    end
    rec_r        <= rec_nxt;
    buy_r.price  <= buy_nxt.price;
    buy_r.id     <= buy_nxt.id;
    buy_r.qty    <= buy_nxt.qty;
    sell_r.price <= sell_nxt.price;
    sell_r.id    <= sell_nxt.id;
    sell_r.qty   <= sell_nxt.qty;
  end

  assign valid_o  = valid_r;
  assign rec_o    = rec_r;
  assign buy_out  = buy_r;
  assign sell_out = sell_r;

endmodule

/* sv/price_time_order_book_unit.sv */
// top level of the price-time order book: request sequencer, cell row and result register
//
// Input channel in_*: one request per transfer, kind in in_tuser, the order fields in
// in_tdata. Output channel out_*: exactly one result per request, status in out_tuser,
// expired count and best buy / best sell in out_tdata, in request order.
// Orders live in a row of ORDER_SLOTS cells packed from cell 0 in arrival order, so
// cell position is time priority. Id and expiry tests are broadcast to all cells at once;
// a removal shifts all the later cells down by one together.
// A request passes the operation state (modify then also the insert state, expire the expire
// state, which removes one expired order at a time until none is left), then the scan state
// while the best-price wave ripples up the cell row, then the done state loading the output
// register. The block works on one request at a time and takes the next one after the load,
// back in the idle state; it accepts no new request while the row sweep of the last one runs.
// A finished result waits in the output register while the next request is already
// accepted and worked on; only the load of the next result waits for out_tready.
// Reset (rst_n low, synchronous) empties the book and drops any pending result.
module price_time_order_book_unit #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // order_id[30:0] is_buy[31] price_ticks[63:32] quantity[95:64] expiry_time[143:96]
  // current_time[190:144] zero[191]
  input  logic [191:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // expired_count[6:0] has_buy[7] best_buy_price[39:8] best_buy_order_id[70:40]
  // best_buy_quantity[102:71] has_sell[103] best_sell_price[135:104]
  // best_sell_order_id[166:136] best_sell_quantity[198:167] zero[199]
  output logic [199:0] out_tdata,
  // status[2:0]
  output logic [2:0]   out_tuser
);

  localparam int CW = $clog2(ORDER_SLOTS + 1);

  pto_pkg::state_t state_r, state_nxt;
  logic [2:0]      kind_r;
  pto_pkg::rec_t   req_r, req_nxt;
  logic [46:0]     now_r;
  logic [2:0]      status_r, status_nxt;
  logic [6:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [199:0]    out_data_r;
  logic [2:0]      out_user_r;
  logic            load_out;
  pto_pkg::cmd_t   cmd;

  logic [ORDER_SLOTS-1:0] valid_v, match_v, ins_v;
  logic [ORDER_SLOTS:0]   rm_c;
  pto_pkg::rec_t          rec_a  [ORDER_SLOTS];
  pto_pkg::best_t         buy_c  [ORDER_SLOTS+1];
  pto_pkg::best_t         sell_c [ORDER_SLOTS+1];
  logic                   any_match;
  logic                   found_buy;
  logic [47:0]            found_exp;
  pto_pkg::best_t         best_buy, best_sell;

  assign rm_c[0]   = 1'b0;
  assign buy_c[0]  = '0;
  assign sell_c[0] = '0;

  genvar g;
  generate
    for (g = 0; g < ORDER_SLOTS; g++) begin : g_cell
      logic          pv, nv;
      pto_pkg::rec_t nr;
      if (g == 0) begin : g_first
        assign pv = 1'b1;
      end else begin : g_mid
        assign pv = valid_v[g-1];
      end
      if (g == ORDER_SLOTS - 1) begin : g_last
        assign nv = 1'b0;
        assign nr = rec_a[g];
      end else begin : g_inner
        assign nv = valid_v[g+1];
        assign nr = rec_a[g+1];
      end
      pto_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prev_valid (pv),
        .next_valid (nv),
        .next_rec   (nr),
        .rm_in      (rm_c[g]),
        .rm_out     (rm_c[g+1]),
        .valid_o    (valid_v[g]),
        .rec_o      (rec_a[g]),
        .match_o    (match_v[g]),
        .ins_o      (ins_v[g]),
        .buy_in     (buy_c[g]),
        .sell_in    (sell_c[g]),
        .buy_out    (buy_c[g+1]),
        .sell_out   (sell_c[g+1])
      );
    end
  endgenerate

  assign best_buy  = buy_c[ORDER_SLOTS];
  assign best_sell = sell_c[ORDER_SLOTS];
  assign any_match = |match_v;

  // ids are unique, so at most one cell matches an id lookup
  always_comb begin
    found_buy = 1'b0;
    found_exp = '0;
    for (int j = 0; j < ORDER_SLOTS; j++) begin
      found_buy = found_buy | (match_v[j] & rec_a[j].buy);
      found_exp = found_exp | (match_v[j] ? rec_a[j].expiry : 48'd0);
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.by_id  = 1'b1;
    cmd.key    = req_r.id;
    cmd.now    = now_r;
    cmd.rec    = req_r;
    state_nxt  = state_r;
    req_nxt    = req_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    scan_nxt   = scan_r;
    load_out   = 1'b0;
    case (state_r)
      pto_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt  = pto_pkg::S_OP;
          status_nxt = pto_pkg::ST_OK;
          cnt_nxt    = '0;
          req_nxt    = '{buy: in_tdata[31], price: in_tdata[63:32], qty: in_tdata[95:64],
                         id: in_tdata[30:0], expiry: in_tdata[143:96]};
        end
      end
      pto_pkg::S_OP: begin
        state_nxt = pto_pkg::S_SCAN;
        scan_nxt  = '0;
        case (kind_r)
          pto_pkg::KIND_ADD: begin
            if (any_match) begin
              status_nxt = pto_pkg::ST_DUPLICATE;
            end else if (valid_v[ORDER_SLOTS-1]) begin
              status_nxt = pto_pkg::ST_FULL;
            end else begin
              cmd.ins_en = 1'b1;
            end
          end
          pto_pkg::KIND_CANCEL: begin
            cmd.rm_en = any_match;
            if (!any_match) begin
              status_nxt = pto_pkg::ST_NOT_FOUND;
            end
          end
          pto_pkg::KIND_MODIFY: begin
            cmd.rm_en = any_match;
            if (any_match) begin
              req_nxt.buy    = found_buy;
              req_nxt.expiry = found_exp;
              state_nxt      = pto_pkg::S_INS;
            end else begin
              status_nxt = pto_pkg::ST_NOT_FOUND;
            end
          end
          pto_pkg::KIND_POPBUY: begin
            cmd.key   = best_buy.id;
            cmd.rm_en = best_buy.has;
            if (!best_buy.has) begin
              status_nxt = pto_pkg::ST_EMPTY;
            end
          end
          pto_pkg::KIND_POPSEL: begin
            cmd.key   = best_sell.id;
            cmd.rm_en = best_sell.has;
            if (!best_sell.has) begin
              status_nxt = pto_pkg::ST_EMPTY;
            end
          end
          pto_pkg::KIND_EXPIRE: begin
            state_nxt = pto_pkg::S_EXP;
          end
          default: begin
          end
        endcase
      end
      pto_pkg::S_INS: begin
        cmd.ins_en = 1'b1;
        state_nxt  = pto_pkg::S_SCAN;
      end
      pto_pkg::S_EXP: begin
        // one expired order leaves per cycle, the first one in the row
        cmd.by_id = 1'b0;
        cmd.rm_en = any_match;
        if (any_match) begin
          if (cnt_r != pto_pkg::CNT_MAX) begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end else begin
          state_nxt = pto_pkg::S_SCAN;
        end
      end
      pto_pkg::S_SCAN: begin
        scan_nxt = scan_r + CW'(1);
        if (scan_r == CW'(ORDER_SLOTS)) begin
          state_nxt = pto_pkg::S_DONE;
        end
      end
      pto_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = pto_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pto_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pto_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    status_r <= status_nxt;
    cnt_r    <= cnt_nxt;
    scan_r   <= scan_nxt;
    if (state_r == pto_pkg::S_IDLE && in_tvalid) begin
      kind_r <= in_tuser;
      now_r  <= in_tdata[190:144];
    end
    if (load_out) begin
      out_user_r <= status_r;
      out_data_r <= {1'b0, best_sell.qty, best_sell.id, best_sell.price, best_sell.has,
                     best_buy.qty, best_buy.id, best_buy.price, best_buy.has, cnt_r};
    end
  end

  assign in_tready  = (state_r == pto_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v >> 1) & ~valid_v) == '0)
    else $error("order cells not packed from cell zero");
  a_ins_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ins_v))
    else $error("insert hit more than one cell");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_en |-> !valid_v[ORDER_SLOTS-1])
    else $error("insert into a full book");
  a_accept_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == pto_pkg::S_OP)
    else $error("accepted request not started");
  a_id_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pto_pkg::S_OP && kind_r == pto_pkg::KIND_CANCEL) |-> $onehot0(match_v))
    else $error("order id rests in two cells");
`endif

endmodule

/* sim/price_time_order_book_unit_tb.sv */
// testbench for the price-time order book: random and directed requests against a book predictor
`timescale 1ns / 100ps

typedef struct {
  logic [2:0]  status;
  logic [6:0]  expired;
  logic        has_buy;
  logic [31:0] buy_price;
  logic [30:0] buy_id;
  logic [31:0] buy_qty;
  logic        has_sell;
  logic [31:0] sell_price;
  logic [30:0] sell_id;
  logic [31:0] sell_qty;
} book_result_t;

class book_scoreboard;
  localparam int SLOTS = 64;
  localparam int FIFO_DEPTH = 16;
  logic        valid [SLOTS];
  logic        buy   [SLOTS];
  logic [31:0] price [SLOTS];
  logic [31:0] qty   [SLOTS];
  logic [30:0] id    [SLOTS];
  logic [47:0] expiry [SLOTS];
  book_result_t exp_fifo [FIFO_DEPTH];
  int wr_ptr;
  int rd_ptr;
  int errors;
  int results_seen;
  int full_hits;
  int expired_total;

  function new();
    foreach (valid[i]) valid[i] = 1'b0;
    wr_ptr = 0;
    rd_ptr = 0;
    errors = 0;
    results_seen = 0;
    full_hits = 0;
    expired_total = 0;
  endfunction

  function int find_id(logic [30:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (valid[i] && id[i] == key) return i;
    return -1;
  endfunction

  // later cells shift down so cell order stays arrival order
  function void remove_at(int idx);
    for (int j = idx; j + 1 < SLOTS; j++) begin
      valid[j] = valid[j+1]; buy[j] = buy[j+1]; price[j] = price[j+1];
      qty[j] = qty[j+1]; id[j] = id[j+1]; expiry[j] = expiry[j+1];
    end
    valid[SLOTS-1] = 1'b0;
  endfunction

  function bit insert(logic b, logic [31:0] p, logic [31:0] q, logic [30:0] k,
                      logic [47:0] e);
    for (int i = 0; i < SLOTS; i++)
      if (!valid[i]) begin
        valid[i] = 1'b1; buy[i] = b; price[i] = p; qty[i] = q; id[i] = k; expiry[i] = e;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function int best_of(logic side);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!valid[i] || buy[i] != side) continue;
      if (best < 0 || (side ? price[i] > price[best] : price[i] < price[best])) best = i;
    end
    return best;
  endfunction

  function int pending();
    return wr_ptr - rd_ptr;
  endfunction

  // accepted request: update the book and queue the result it must produce
  function void note(logic [2:0] kind, logic [30:0] k, logic b, logic [31:0] p,
                     logic [31:0] q, logic [47:0] e, logic [46:0] now);
    book_result_t r;
    int i, bb, ss;
    logic s_side;
    logic [47:0] s_exp;
    r.status = pto_pkg::ST_OK;
    r.expired = '0;
    case (kind)
      pto_pkg::KIND_ADD: begin
        if (find_id(k) >= 0) r.status = pto_pkg::ST_DUPLICATE;
        else if (!insert(b, p, q, k, e)) begin
          r.status = pto_pkg::ST_FULL;
          full_hits++;
        end
      end
      pto_pkg::KIND_CANCEL: begin
        i = find_id(k);
        if (i < 0) r.status = pto_pkg::ST_NOT_FOUND;
        else remove_at(i);
      end
      pto_pkg::KIND_MODIFY: begin
        i = find_id(k);
        if (i < 0) r.status = pto_pkg::ST_NOT_FOUND;
        else begin
          s_side = buy[i];
          s_exp = expiry[i];
          remove_at(i);
          void'(insert(s_side, p, q, k, s_exp));
        end
      end
      pto_pkg::KIND_POPBUY, pto_pkg::KIND_POPSEL: begin
        i = best_of(kind == pto_pkg::KIND_POPBUY);
        if (i < 0) r.status = pto_pkg::ST_EMPTY;
        else remove_at(i);
      end
      pto_pkg::KIND_EXPIRE: begin
        i = 0;
        while (i < SLOTS && valid[i]) begin
          if (expiry[i] != pto_pkg::NO_EXPIRY &&
              $signed(expiry[i]) <= $signed({1'b0, now})) begin
            remove_at(i);
            if (r.expired < pto_pkg::CNT_MAX) r.expired++;
          end else i++;
        end
        expired_total += r.expired;
      end
      default: ;
    endcase
    bb = best_of(1'b1);
    ss = best_of(1'b0);
    r.has_buy   = bb >= 0;
    r.buy_price = bb >= 0 ? price[bb] : '0;
    r.buy_id    = bb >= 0 ? id[bb] : '0;
    r.buy_qty   = bb >= 0 ? qty[bb] : '0;
    r.has_sell   = ss >= 0;
    r.sell_price = ss >= 0 ? price[ss] : '0;
    r.sell_id    = ss >= 0 ? id[ss] : '0;
    r.sell_qty   = ss >= 0 ? qty[ss] : '0;
    exp_fifo[wr_ptr % FIFO_DEPTH] = r;
    wr_ptr++;
  endfunction

  function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, field, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check(logic [199:0] d, logic [2:0] u);
    book_result_t r;
    if (wr_ptr == rd_ptr) begin
      $display("%0t unexpected result: expected none actual %h / %h", $time, u, d);
      errors++;
      return;
    end
    r = exp_fifo[rd_ptr % FIFO_DEPTH];
    rd_ptr++;
    results_seen++;
    cmp("status", r.status, u);
    cmp("expired_count", r.expired, d[6:0]);
    cmp("has_buy", r.has_buy, d[7]);
    cmp("best_buy_price", r.buy_price, d[39:8]);
    cmp("best_buy_order_id", r.buy_id, d[70:40]);
    cmp("best_buy_quantity", r.buy_qty, d[102:71]);
    cmp("has_sell", r.has_sell, d[103]);
    cmp("best_sell_price", r.sell_price, d[135:104]);
    cmp("best_sell_order_id", r.sell_id, d[166:136]);
    cmp("best_sell_quantity", r.sell_qty, d[198:167]);
    cmp("pad", 32'd0, d[199]);
  endfunction
endclass

module price_time_order_book_unit_tb;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [199:0] out_tdata;
  logic [2:0]   out_tuser;

  book_scoreboard book;
  int send_idle, recv_idle;
  int hold_req, hold_seen, hold_left;
  int stall_cnt;
  int items_sent;
  longint unsigned clock_now;

  price_time_order_book_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  // receiver: random backpressure plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) book.check(out_tdata, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_req(logic [2:0] kind, logic [30:0] k, logic b, logic [31:0] p,
                          logic [31:0] q, logic [47:0] e, logic [46:0] now);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, now, e, q, p, b, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note(kind, k, b, p, q, e, now);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // mostly well-formed traffic on a small id pool so ids collide and the book fills
  task automatic random_req(int fill_bias);
    logic [2:0]  kind;
    logic [30:0] k;
    logic [31:0] p;
    logic [47:0] e;
    logic [46:0] now;
    int pick, sel;
    pick = $urandom_range(0, 99);
    if (pick < fill_bias) kind = pto_pkg::KIND_ADD;
    else if (pick < fill_bias + (100 - fill_bias) * 25 / 100) kind = pto_pkg::KIND_CANCEL;
    else if (pick < fill_bias + (100 - fill_bias) * 45 / 100) kind = pto_pkg::KIND_MODIFY;
    else if (pick < fill_bias + (100 - fill_bias) * 62 / 100) kind = pto_pkg::KIND_POPBUY;
    else if (pick < fill_bias + (100 - fill_bias) * 79 / 100) kind = pto_pkg::KIND_POPSEL;
    else if (pick < 97) kind = pto_pkg::KIND_EXPIRE;
    else kind = 3'($urandom_range(6, 7));
    k = 31'($urandom_range(0, 79));
    if ($urandom_range(0, 3) == 0) k = k | 31'h7FFF_FF80;
    if ($urandom_range(0, 19) == 0) k = 31'($urandom);
    p = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(100, 107));
    sel = $urandom_range(0, 9);
    if (sel < 3) e = pto_pkg::NO_EXPIRY;
    else if (sel < 7) e = 48'(clock_now + $urandom_range(0, 60));
    else if (sel < 8) e = {1'b1, 15'($urandom), $urandom};
    else e = {16'($urandom), $urandom};
    if (kind == pto_pkg::KIND_EXPIRE) clock_now += $urandom_range(0, 20);
    now = ($urandom_range(0, 9) == 0) ? {15'($urandom), $urandom} : 47'(clock_now);
    send_req(kind, k, 1'($urandom), p, $urandom, e, now);
  endtask

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      random_req(n < 80 ? 80 : 40);
      if (n == count / 2) hold_req++;
    end
  endtask

  initial begin
    book = new();
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    stall_cnt = 0;
    items_sent = 0;
    clock_now = 1000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, field extremes, duplicates, ties, expiry corners, unused kinds
    send_req(pto_pkg::KIND_POPBUY, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_POPSEL, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_ADD, 31'd0, 1'b1, 32'd0, 32'd0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_ADD, 31'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             pto_pkg::NO_EXPIRY, 47'h7FFF_FFFF_FFFF);
    send_req(pto_pkg::KIND_ADD, 31'h7FFF_FFFF, 1'b1, 32'd5, 32'd5, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_ADD, 31'd10, 1'b1, 32'd50, 32'd1, 48'h7FFF_FFFF_FFFF, '0);
    send_req(pto_pkg::KIND_ADD, 31'd11, 1'b1, 32'd50, 32'd2, -48'sd5, '0);
    send_req(pto_pkg::KIND_ADD, 31'd12, 1'b0, 32'd70, 32'd3, 48'd100, '0);
    send_req(pto_pkg::KIND_ADD, 31'd13, 1'b0, 32'd70, 32'd4, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_CANCEL, 31'd99, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_MODIFY, 31'd98, 1'b0, 32'd1, 32'd1, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_MODIFY, 31'd10, 1'b0, 32'd50, 32'd9, pto_pkg::NO_EXPIRY, '0);
    send_req(3'd6, 31'd1, 1'b1, 32'd1, 32'd1, pto_pkg::NO_EXPIRY, '0);
    send_req(3'd7, 31'h7FFF_FFFF, 1'b1, '1, '1, '1, '1);
    send_req(pto_pkg::KIND_EXPIRE, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, 47'd0);
    send_req(pto_pkg::KIND_EXPIRE, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, 47'd100);
    send_req(pto_pkg::KIND_POPBUY, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_POPSEL, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_CANCEL, 31'h7FFF_FFFF, 1'b0, '0, '0, pto_pkg::NO_EXPIRY, '0);
    send_req(pto_pkg::KIND_EXPIRE, '0, 1'b0, '0, '0, pto_pkg::NO_EXPIRY,
             47'h7FFF_FFFF_FFFF);
    // sender pause until the book has answered everything
    wait_drained();

    send_idle = 26;
    recv_idle = 53;
    random_phase(200);
    wait_drained();
    send_idle = 53;
    recv_idle = 26;
    random_phase(200);
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    random_phase(200);
    wait_drained();
    repeat (80) @(posedge clk);

    $display("ran %0d requests, %0d results checked, %0d book-full rejects, %0d orders expired",
             items_sent, book.results_seen, book.full_hits, book.expired_total);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
